// File: design/linear_probe_key_set_core_macros.svh
// ----------------------------------------------------------------------------
// Linear probe key set assertion macros
// Shared concurrent assertion forms used by the key set core.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_KEY_SET_CORE_MACROS_SVH
`define LINEAR_PROBE_KEY_SET_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPKS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lpks_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe key set package
// Types and fixed constants shared by the key set modules.
// ----------------------------------------------------------------------------
package lpks_pkg;

  localparam int KEY_W       = 64;
  localparam int CFG_W       = 5;
  localparam int COUNT_OUT_W = 17;

  localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 5'd16;
  localparam logic [KEY_W-1:0] EMPTY_KEY      = {KEY_W{1'b1}};

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } lpks_op_t;

  typedef struct packed {
    logic                   valid;
    logic                   is_new;
    logic                   table_full;
    logic [COUNT_OUT_W-1:0] entry_count;
  } lpks_result_t;

endpackage

// File: design/lpks_queue.sv
// ----------------------------------------------------------------------------
// Linear probe key set queue
// Two-entry first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module lpks_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] entries [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full     = (fill == 2'(DEPTH));
  assign valid    = (fill != 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// File: design/lpks_front.sv
// ----------------------------------------------------------------------------
// Linear probe key set front end
// Holds the size register, accepts commands and works out the home slot.
// ----------------------------------------------------------------------------
module lpks_front #(
  parameter int MAX_SLOT_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cap_log2_we,
  input  logic [lpks_pkg::CFG_W-1:0]                   cap_log2,
  input  logic                                         start,
  output logic                                         busy,
  input  logic                                         cmd,
  input  logic [lpks_pkg::KEY_W-1:0]                   key,
  input  logic                                         init_busy,
  input  logic                                         q_full,
  output logic                                         q_push,
  output lpks_pkg::lpks_op_t                           item_op,
  output logic [lpks_pkg::KEY_W-1:0]                   item_key,
  output logic [MAX_SLOT_BITS-1:0]                     item_home,
  output logic [$clog2(MAX_SLOT_BITS+1)-1:0]           item_eff
);

  import lpks_pkg::*;

  localparam int AW  = MAX_SLOT_BITS;
  localparam int EBW = $clog2(MAX_SLOT_BITS + 1);

  logic [CFG_W-1:0] cap_reg;
  logic             hold_valid;
  logic [EBW-1:0]   eff;
  logic [AW:0]      slots;
  logic [AW-1:0]    mask;
  logic             accept;

  always_comb begin
    if (cap_reg == '0) begin
      eff = EBW'(1);
    end else if (cap_reg > CFG_W'(MAX_SLOT_BITS)) begin
      eff = EBW'(MAX_SLOT_BITS);
    end else begin
      eff = EBW'(cap_reg);
    end
  end

  assign slots  = (AW+1)'(1) << eff;
  assign mask   = AW'(slots - (AW+1)'(1));
  assign busy   = init_busy || (hold_valid && q_full);
  assign accept = start && !busy;
  assign q_push = hold_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_LOG2_RESET;
    end else if (cap_log2_we) begin
      cap_reg <= cap_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op   <= lpks_op_t'(cmd);
      item_key  <= key;
      item_home <= key[AW-1:0] & mask;
      item_eff  <= eff;
    end
  end

endmodule

// File: design/lpks_back.sv
// ----------------------------------------------------------------------------
// Linear probe key set back end
// Runs the load check, the linear probe and the clearing sweep on the table.
// ----------------------------------------------------------------------------
module lpks_back #(
  parameter int MAX_SLOT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  lpks_pkg::lpks_op_t                 q_op,
  input  logic [lpks_pkg::KEY_W-1:0]         q_key,
  input  logic [MAX_SLOT_BITS-1:0]           q_home,
  input  logic [$clog2(MAX_SLOT_BITS+1)-1:0] q_eff,
  output logic                               init_busy,
  output lpks_pkg::lpks_result_t             res
);

  import lpks_pkg::*;

  localparam int AW    = MAX_SLOT_BITS;
  localparam int EBW   = $clog2(MAX_SLOT_BITS + 1);
  localparam int CW    = MAX_SLOT_BITS + 1;
  localparam int LW    = CW + 4;
  localparam int DEPTH = 1 << MAX_SLOT_BITS;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_PROBE = 3'b100
  } back_state_t;

  back_state_t      state;
  logic [AW-1:0]    sweep_addr;
  logic             sweep_report;
  logic [KEY_W-1:0] cur_key;
  logic [AW-1:0]    cur_idx;
  logic [EBW-1:0]   cur_eff;
  logic [CW-1:0]    probe_n;
  logic [CW-1:0]    count;
  logic             full_flag;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wdata;

  logic [CW-1:0]    q_slots;
  logic [LW-1:0]    load_lhs;
  logic [LW-1:0]    load_rhs;
  logic             at_limit;
  logic [CW-1:0]    cur_slots;
  logic [AW-1:0]    cur_mask;
  logic [AW-1:0]    idx_next;
  logic             slot_empty;
  logic             probe_end;

  assign q_slots   = CW'(1) << q_eff;
  assign load_lhs  = (LW'(count) << 3) + (LW'(count) << 1);
  assign load_rhs  = LW'(q_slots) << 3;
  assign at_limit  = (load_lhs >= load_rhs);

  assign cur_slots  = CW'(1) << cur_eff;
  assign cur_mask   = AW'(cur_slots - CW'(1));
  assign idx_next   = (cur_idx + AW'(1)) & cur_mask;
  assign slot_empty = (rdata == EMPTY_KEY);
  assign probe_end  = (rdata == cur_key) || (probe_n == cur_slots - CW'(1));

  assign q_pop     = q_valid && (state == S_IDLE);
  assign init_busy = (state == S_SWEEP) && !sweep_report;

  always_comb begin
    rd_addr = q_home;
    we      = 1'b0;
    waddr   = cur_idx;
    wdata   = cur_key;
    case (state)
      S_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_addr;
        wdata = EMPTY_KEY;
      end
      S_PROBE: begin
        rd_addr = idx_next;
        we      = slot_empty;
      end
      default: begin
        rd_addr = q_home;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_addr   <= '0;
      sweep_report <= 1'b0;
      count        <= '0;
      full_flag    <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_op == OP_CLEAR) begin
              sweep_addr   <= '0;
              sweep_report <= 1'b1;
              state        <= S_SWEEP;
            end else if (at_limit) begin
              full_flag       <= 1'b1;
              res.valid       <= 1'b1;
              res.is_new      <= 1'b0;
              res.table_full  <= 1'b1;
              res.entry_count <= COUNT_OUT_W'(count);
            end else begin
              cur_key <= q_key;
              cur_idx <= q_home;
              cur_eff <= q_eff;
              probe_n <= '0;
              state   <= S_PROBE;
            end
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (&sweep_addr) begin
            state <= S_IDLE;
            if (sweep_report) begin
              count           <= '0;
              full_flag       <= 1'b0;
              res.valid       <= 1'b1;
              res.is_new      <= 1'b0;
              res.table_full  <= 1'b0;
              res.entry_count <= '0;
            end
          end
        end
        S_PROBE: begin
          if (slot_empty) begin
            count           <= count + CW'(1);
            res.valid       <= 1'b1;
            res.is_new      <= 1'b1;
            res.table_full  <= full_flag;
            res.entry_count <= COUNT_OUT_W'(count + CW'(1));
            state           <= S_IDLE;
          end else if (probe_end) begin
            res.valid       <= 1'b1;
            res.is_new      <= 1'b0;
            res.table_full  <= full_flag;
            res.entry_count <= COUNT_OUT_W'(count);
            state           <= S_IDLE;
          end else begin
            cur_idx <= idx_next;
            probe_n <= probe_n + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/linear_probe_key_set_core.sv
// ----------------------------------------------------------------------------
// Linear probe key set core
// Open-addressed set of 64-bit keys with linear probing and a load limit.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low: cmd selects an
// insert of key or a clear of the whole table. Every command produces one
// result transaction, shown for a single cycle with done high, carrying
// is_new, table_full and entry_count. The receiver cannot stall, so results
// are never held back. The size register is written through cap_log2_we and
// cap_log2; the user must do so only while the block is idle; the block does not enforce it.
// An insert probes slots in turn from its home slot, wrapping within the
// table size, until it finds the key, finds an empty slot or has tried
// every slot; an insert refused by the load limit does not probe. A clear
// sweeps all 2^MAX_SLOT_BITS table entries, one entry per cycle. The back
// end handles one transaction at a time, paced by the table memory, while
// the front end and a two-entry queue keep taking commands until both are
// full. After reset the table is swept to empty with busy held high; the
// size register returns to 16 and the count and full flag to zero.
// ----------------------------------------------------------------------------
`include "linear_probe_key_set_core_macros.svh"

module linear_probe_key_set_core #(
  parameter int MAX_SLOT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cap_log2_we,
  input  logic [lpks_pkg::CFG_W-1:0]             cap_log2,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   cmd,
  input  logic [lpks_pkg::KEY_W-1:0]             key,
  output logic                                   done,
  output logic                                   is_new,
  output logic                                   table_full,
  output logic [lpks_pkg::COUNT_OUT_W-1:0]       entry_count
);

  import lpks_pkg::*;

  localparam int AW  = MAX_SLOT_BITS;
  localparam int EBW = $clog2(MAX_SLOT_BITS + 1);
  localparam int QW  = 1 + KEY_W + AW + EBW;

  logic             init_busy;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  logic [QW-1:0]    q_wdata;
  logic [QW-1:0]    q_rdata;
  lpks_op_t         f_op;
  logic [KEY_W-1:0] f_key;
  logic [AW-1:0]    f_home;
  logic [EBW-1:0]   f_eff;
  lpks_result_t     res;

  lpks_front #(
    .MAX_SLOT_BITS(MAX_SLOT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cap_log2_we(cap_log2_we),
    .cap_log2   (cap_log2),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .key        (key),
    .init_busy  (init_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .item_op    (f_op),
    .item_key   (f_key),
    .item_home  (f_home),
    .item_eff   (f_eff)
  );

  assign q_wdata = {f_op, f_key, f_home, f_eff};

  lpks_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_data (q_rdata)
  );

  lpks_back #(
    .MAX_SLOT_BITS(MAX_SLOT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (lpks_op_t'(q_rdata[QW-1])),
    .q_key    (q_rdata[QW-2 -: KEY_W]),
    .q_home   (q_rdata[EBW +: AW]),
    .q_eff    (q_rdata[EBW-1:0]),
    .init_busy(init_busy),
    .res      (res)
  );

  assign done        = res.valid;
  assign is_new      = res.is_new;
  assign table_full  = res.table_full;
  assign entry_count = res.entry_count;

  `LPKS_ASSERT_IMPL(a_queue_no_overflow, clk, rst, q_push, !q_full, "queue push while full")
  `LPKS_ASSERT_IMPL(a_no_result_in_init, clk, rst, done, !init_busy, "result during init sweep")
  `LPKS_ASSERT_NEXT(a_push_fills_queue, clk, rst, q_push && !q_pop, q_valid, "queue lost an entry")

endmodule
